### src/alle_pkg.sv
`default_nettype none

package alle_pkg;

   localparam int SLOTS = 256;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int PAY_W = 64;
   localparam int REQ_W = 80;
   localparam int RSP_W = 112;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [PAY_W-1:0] payload_type;

   typedef enum logic [1:0] {
      CMD_INS_AFTER,
      CMD_INS_BEFORE,
      CMD_DELETE,
      CMD_READ
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_POS,
      STATUS_FULL
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_WRITE,
      S_DONE
   } state_type;

   // predecessor memory word, in-use flag rides along with the link
   typedef struct packed {
      logic     in_use;
      slot_type link;
   } prev_entry_type;

   // first member sits in the highest bits
   typedef struct packed {
      slot_type    prv;
      slot_type    nxt;
      payload_type payload;
      slot_type    count;
      slot_type    tail;
      slot_type    slot;
      status_type  status;
   } rsp_type;

   function automatic slot_type next_reset(slot_type idx);
      slot_type r;
      if (idx == '0 || idx == slot_type'(SLOTS - 1)) begin
         r = '0;
      end else begin
         r = idx + slot_type'(1);
      end
      return r;
   endfunction

   function automatic prev_entry_type prev_reset(slot_type idx);
      prev_entry_type r;
      r.in_use = (idx == '0);
      r.link = '0;
      return r;
   endfunction

endpackage

`default_nettype wire

### src/array_linked_list_engine_top.sv
// a request passes S_READ, S_WRITE and S_DONE, and the response is registered as S_DONE loads it;
//   S_DONE holds while an earlier response waits. One request at a time, set by the read, two
//   write steps and the response load around the single write port of each link memory
// reset: synchronous, active high; a clearing pass then loads the link
//   memories with the initial free chain, and requests are held off until it ends
`default_nettype none

module array_linked_list_engine_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cmd[1:0], pos[9:2], value[73:10], zero fill
   input  wire logic [79:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], slot[9:2], tail_slot[17:10], count[25:18], read_payload[89:26],
   // read_next[97:90], read_prev[105:98], zero fill
   output logic [111:0]      rsp_tdata
);

   import alle_pkg::*;

   // memories
   slot_type       next_mem [SLOTS];
   prev_entry_type prev_mem [SLOTS];
   payload_type    pay_mem [SLOTS];

   // write ports
   logic           nx_we;
   slot_type       nx_wa;
   slot_type       nx_wd;
   logic           pv_we;
   slot_type       pv_wa;
   prev_entry_type pv_wd;
   logic           pl_we;
   slot_type       pl_wa;

   // read data
   logic           rd_en;
   slot_type       req_pos;
   slot_type       rd_next_ff;
   slot_type       rd_free_next_ff;
   prev_entry_type rd_prev_ff;
   payload_type    rd_pay_ff;

   slot_type       nx_cur;
   slot_type       nf_cur;
   prev_entry_type pv_cur;

   state_type      state_ff, state_in;
   slot_type       init_idx_ff, init_idx_in;
   cmd_type        cmd_ff, cmd_in;
   slot_type       pos_ff, pos_in;
   payload_type    value_ff, value_in;
   slot_type       free_head_ff, free_head_in;
   slot_type       last_ff, last_in;
   slot_type       count_ff, count_in;
   rsp_type        res_ff, res_in;
   logic           wr2_ff, wr2_in;
   slot_type       nx2_addr_ff, nx2_addr_in;
   slot_type       nx2_data_ff, nx2_data_in;
   slot_type       pv2_addr_ff, pv2_addr_in;
   prev_entry_type pv2_data_ff, pv2_data_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   assign req_pos = req_tdata[9:2];

   always_ff @(posedge clock) begin
      if (nx_we) begin
         next_mem[nx_wa] <= nx_wd;
      end
      if (pv_we) begin
         prev_mem[pv_wa] <= pv_wd;
      end
      if (pl_we) begin
         pay_mem[pl_wa] <= value_ff;
      end
      if (rd_en) begin
         rd_next_ff <= next_mem[req_pos];
         rd_free_next_ff <= next_mem[free_head_ff];
         rd_prev_ff <= prev_mem[req_pos];
         rd_pay_ff <= pay_mem[req_pos];
      end
   end

   assign nx_cur = rd_next_ff;
   assign nf_cur = rd_free_next_ff;
   assign pv_cur = rd_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_idx_ff <= '0;
         free_head_ff <= slot_type'(1);
         last_ff <= '0;
         count_ff <= '0;
         wr2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_idx_ff <= init_idx_in;
         free_head_ff <= free_head_in;
         last_ff <= last_in;
         count_ff <= count_in;
         wr2_ff <= wr2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      pos_ff <= pos_in;
      value_ff <= value_in;
      res_ff <= res_in;
      nx2_addr_ff <= nx2_addr_in;
      nx2_data_ff <= nx2_data_in;
      pv2_addr_ff <= pv2_addr_in;
      pv2_data_ff <= pv2_data_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      slot_type ins_at;
      slot_type ins_succ;

      ins_at = '0;
      ins_succ = '0;
      state_in = state_ff;
      init_idx_in = init_idx_ff;
      cmd_in = cmd_ff;
      pos_in = pos_ff;
      value_in = value_ff;
      free_head_in = free_head_ff;
      last_in = last_ff;
      count_in = count_ff;
      res_in = res_ff;
      wr2_in = wr2_ff;
      nx2_addr_in = nx2_addr_ff;
      nx2_data_in = nx2_data_ff;
      pv2_addr_in = pv2_addr_ff;
      pv2_data_in = pv2_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      req_tready = (state_ff == S_IDLE);
      rd_en = 1'b0;
      nx_we = 1'b0;
      nx_wa = '0;
      nx_wd = '0;
      pv_we = 1'b0;
      pv_wa = '0;
      pv_wd = '0;
      pl_we = 1'b0;
      pl_wa = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            // load one entry of the initial free chain per cycle
            nx_we = 1'b1;
            nx_wa = init_idx_ff;
            nx_wd = next_reset(init_idx_ff);
            pv_we = 1'b1;
            pv_wa = init_idx_ff;
            pv_wd = prev_reset(init_idx_ff);
            init_idx_in = init_idx_ff + slot_type'(1);
            if (init_idx_ff == slot_type'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               rd_en = 1'b1;
               cmd_in = cmd_type'(req_tdata[1:0]);
               pos_in = req_pos;
               value_in = req_tdata[73:10];
               state_in = S_READ;
            end
         end
         S_READ: begin
            res_in = '0;
            res_in.status = STATUS_OK;
            wr2_in = 1'b0;
            if (!pv_cur.in_use) begin
               res_in.status = STATUS_BAD_POS;
            end else if (cmd_ff == CMD_INS_AFTER || cmd_ff == CMD_INS_BEFORE) begin
               if (free_head_ff == '0) begin
                  res_in.status = STATUS_FULL;
               end else begin
                  // insert before links after the predecessor of pos
                  ins_at = (cmd_ff == CMD_INS_AFTER) ? pos_ff : pv_cur.link;
                  ins_succ = (cmd_ff == CMD_INS_AFTER) ? nx_cur : pos_ff;
                  nx_we = 1'b1;
                  nx_wa = ins_at;
                  nx_wd = free_head_ff;
                  pv_we = 1'b1;
                  pv_wa = free_head_ff;
                  pv_wd.in_use = 1'b1;
                  pv_wd.link = ins_at;
                  pl_we = 1'b1;
                  pl_wa = free_head_ff;
                  wr2_in = 1'b1;
                  nx2_addr_in = free_head_ff;
                  nx2_data_in = ins_succ;
                  pv2_addr_in = ins_succ;
                  pv2_data_in.in_use = 1'b1;
                  pv2_data_in.link = free_head_ff;
                  free_head_in = nf_cur;
                  if (ins_succ == '0) begin
                     last_in = free_head_ff;
                  end
                  count_in = count_ff + slot_type'(1);
                  res_in.slot = free_head_ff;
               end
            end else if (cmd_ff == CMD_DELETE) begin
               if (pos_ff == '0) begin
                  res_in.status = STATUS_BAD_POS;
               end else begin
                  nx_we = 1'b1;
                  nx_wa = pv_cur.link;
                  nx_wd = nx_cur;
                  pv_we = 1'b1;
                  pv_wa = nx_cur;
                  pv_wd.in_use = 1'b1;
                  pv_wd.link = pv_cur.link;
                  // freed slot goes to the front of the free chain
                  wr2_in = 1'b1;
                  nx2_addr_in = pos_ff;
                  nx2_data_in = free_head_ff;
                  pv2_addr_in = pos_ff;
                  pv2_data_in = '0;
                  if (pos_ff == last_ff) begin
                     last_in = pv_cur.link;
                  end
                  free_head_in = pos_ff;
                  count_in = count_ff - slot_type'(1);
                  res_in.slot = pos_ff;
               end
            end else begin
               res_in.slot = pos_ff;
               res_in.payload = (pos_ff == '0) ? '0 : rd_pay_ff;
               res_in.nxt = nx_cur;
               res_in.prv = pv_cur.link;
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (wr2_ff) begin
               nx_we = 1'b1;
               nx_wa = nx2_addr_ff;
               nx_wd = nx2_data_ff;
               pv_we = 1'b1;
               pv_wa = pv2_addr_ff;
               pv_wd = pv2_data_ff;
            end
            wr2_in = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in = res_ff;
               rsp_in.tail = last_ff;
               rsp_in.count = count_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {(RSP_W - $bits(rsp_type))'(0), rsp_ff};

   // free chain empty exactly when the list holds every usable slot
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff == '0) == (count_ff == slot_type'(SLOTS - 1)))
      else $error("free chain and element count disagree");

   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.status == STATUS_FULL |-> rsp_ff.count == slot_type'(SLOTS - 1))
      else $error("full status with room left");

   a_err_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.status != STATUS_OK |-> rsp_ff.slot == '0 && rsp_ff.payload == '0)
      else $error("failed request reports a slot");

   a_no_late_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !wr2_ff && !nx_we && !pv_we)
      else $error("link write pending while taking a request");

endmodule

`default_nettype wire
